FILE: src/dol_pkg.sv
package dol_pkg;

    // Fixed sizes of the dendrite store and the input vector.
    localparam int INPUT_BITS    = 1024;
    localparam int MAX_DENDRITES = 256;
    localparam int MAX_RECEPTORS = 32;
    localparam int VEC_WORDS     = INPUT_BITS / 64;
    localparam int SLOTS         = MAX_DENDRITES * MAX_RECEPTORS;
    localparam int SLOT_AW       = $clog2(SLOTS);
    localparam int SLOT_W        = 17;

    localparam logic [6:0] PERM_TOP = 7'd99;

    // Item kinds as they arrive on the input channel.
    localparam logic [2:0] KIND_LOAD    = 3'd0;
    localparam logic [2:0] KIND_WRITE   = 3'd1;
    localparam logic [2:0] KIND_OVERLAP = 3'd2;
    localparam logic [2:0] KIND_LEARN   = 3'd3;
    localparam logic [2:0] KIND_PUNISH  = 3'd4;
    localparam logic [2:0] KIND_MOVE    = 3'd5;
    localparam logic [2:0] KIND_READ    = 3'd6;

    // Configuration register indexes.
    localparam logic [2:0] REG_THRESHOLD = 3'd0;
    localparam logic [2:0] REG_INCREMENT = 3'd1;
    localparam logic [2:0] REG_DECREMENT = 3'd2;
    localparam logic [2:0] REG_RECEPTORS = 3'd3;
    localparam logic [2:0] REG_DENDRITES = 3'd4;

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  word_index;
        logic [63:0] word_data;
        logic [7:0]  dendrite;
        logic [4:0]  receptor;
        logic [9:0]  receptor_address;
        logic [6:0]  receptor_permanence;
        logic [31:0] learn_mask;
    } in_t;

    typedef struct packed {
        logic [5:0] overlap_count;
        logic [9:0] read_address;
        logic [6:0] read_permanence;
    } out_t;

    // Classified operation handed from the front to the back.
    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_WRITE,
        OP_READ,
        OP_OVERLAP,
        OP_LEARN,
        OP_PUNISH,
        OP_MOVE
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [3:0]  word_index;
        logic [63:0] word_data;
        logic [7:0]  dendrite;
        logic [4:0]  receptor;
        logic [9:0]  address;
        logic [6:0]  permanence;
        logic [31:0] learn_mask;
    } cmd_t;

    // Effective configuration seen by the back.
    typedef struct packed {
        logic [6:0] threshold;
        logic [6:0] increment;
        logic [6:0] decrement;
        logic [5:0] receptors;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_WALK_RD,
        ST_WALK_EX,
        ST_FREE_RD,
        ST_FREE_EX,
        ST_MOVE_RD,
        ST_MOVE_EX,
        ST_SEARCH
    } state_t;

    // Raise a permanence, saturating at the top value.
    function automatic logic [6:0] perm_up(input logic [6:0] p, input logic [6:0] amount);
        logic [7:0] v;
        v = {1'b0, p} + {1'b0, amount};
        return (v > {1'b0, PERM_TOP}) ? PERM_TOP : v[6:0];
    endfunction

    // Lower a permanence, saturating at zero.
    function automatic logic [6:0] perm_down(input logic [6:0] p, input logic [6:0] amount);
        return (p > amount) ? (p - amount) : 7'd0;
    endfunction

    // Position of the lowest set bit of a word.
    function automatic logic [5:0] lowest_set(input logic [63:0] bits);
        logic [5:0] pos;
        pos = 6'd0;
        for (int i = 63; i >= 0; i--) begin
            if (bits[i])
            begin
                pos = 6'(i);
            end
        end
        return pos;
    endfunction

endpackage

FILE: src/dol_ram.sv
module dol_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: src/dol_front.sv
module dol_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          item_valid,
    output logic          item_stall,
    input  dol_pkg::in_t  item,
    input  logic [5:0]    receptors,
    input  logic [8:0]    dendrites,
    input  logic          clearing,
    input  logic          q_pop,
    output logic          q_valid,
    output dol_pkg::cmd_t q_cmd
);
    import dol_pkg::*;

    cmd_t       cmd;
    logic       d_ok;
    logic       r_ok;
    logic       push;
    cmd_t       entry_reg [2];
    logic       wp_reg;
    logic       wp_next;
    logic       rp_reg;
    logic       rp_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;

    // Classify the item, check its ranges and clamp its permanence.
    always_comb
    begin
        d_ok = {1'b0, item.dendrite} < dendrites;
        r_ok = {1'b0, item.receptor} < receptors;
        cmd.word_index = item.word_index;
        cmd.word_data  = item.word_data;
        cmd.dendrite   = item.dendrite;
        cmd.receptor   = item.receptor;
        cmd.address    = item.receptor_address;
        cmd.permanence = (item.receptor_permanence > PERM_TOP) ? PERM_TOP
                                                               : item.receptor_permanence;
        cmd.learn_mask = item.learn_mask;
        case (item.kind)
            KIND_LOAD:    cmd.op = OP_LOAD;
            KIND_WRITE:   cmd.op = (d_ok && r_ok) ? OP_WRITE : OP_NOP;
            KIND_READ:    cmd.op = (d_ok && r_ok) ? OP_READ : OP_NOP;
            KIND_OVERLAP: cmd.op = d_ok ? OP_OVERLAP : OP_NOP;
            KIND_LEARN:   cmd.op = d_ok ? OP_LEARN : OP_NOP;
            KIND_PUNISH:  cmd.op = d_ok ? OP_PUNISH : OP_NOP;
            KIND_MOVE:    cmd.op = d_ok ? OP_MOVE : OP_NOP;
            default:      cmd.op = OP_NOP;
        endcase
    end

    // Two-entry queue toward the back.
    assign item_stall = (cnt_reg == 2'd2) || clearing;
    assign push       = item_valid && !item_stall;
    assign q_valid    = (cnt_reg != 2'd0);
    assign q_cmd      = entry_reg[rp_reg];

    always_comb
    begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = q_pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    // Queue payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wp_reg] <= cmd;
        end
    end

endmodule

FILE: src/dol_back.sv
module dol_back (
    input  logic          clk,
    input  logic          rst_n,
    input  dol_pkg::cfg_t cfg,
    input  logic          q_valid,
    input  dol_pkg::cmd_t q_cmd,
    output logic          q_pop,
    output logic          clearing,
    output logic          result_valid,
    input  logic          result_stall,
    output dol_pkg::out_t result
);
    import dol_pkg::*;

    state_t                            state_reg;
    state_t                            state_next;
    cmd_t                              cmd_reg;
    cmd_t                              cmd_next;
    logic [4:0]                        r_reg;
    logic [4:0]                        r_next;
    logic [5:0]                        ov_reg;
    logic [5:0]                        ov_next;
    logic [10:0]                       nxt_reg;
    logic [10:0]                       nxt_next;
    logic [SLOT_AW-1:0]                clr_reg;
    logic [SLOT_AW-1:0]                clr_next;
    logic [VEC_WORDS-1:0][63:0]        vec_reg;
    logic [VEC_WORDS-1:0][63:0]        vec_next;
    logic [VEC_WORDS-1:0][63:0]        avail_reg;
    logic [VEC_WORDS-1:0][63:0]        avail_next;
    logic                              res_valid_reg;
    logic                              res_valid_next;
    out_t                              res_reg;
    out_t                              res_next;

    logic                              ram_we;
    logic [SLOT_AW-1:0]                ram_waddr;
    logic [SLOT_W-1:0]                 ram_wdata;
    logic [SLOT_AW-1:0]                ram_raddr;
    logic [SLOT_W-1:0]                 ram_rdata;

    logic [SLOT_AW-1:0]                slot;
    logic [9:0]                        rd_addr;
    logic [6:0]                        rd_perm;
    logic                              act;
    logic                              masked;
    logic                              last;
    logic [63:0]                       bits;
    logic [5:0]                        pos;

    dol_ram #(
        .WIDTH(SLOT_W),
        .DEPTH(SLOTS)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign clearing     = (state_reg == ST_CLEAR);
    assign result_valid = res_valid_reg;
    assign result       = res_reg;
    assign q_pop        = (state_reg == ST_IDLE) && q_valid && !res_valid_reg;

    // Fields of the slot being walked.
    assign slot    = {cmd_reg.dendrite, r_reg};
    assign rd_addr = ram_rdata[16:7];
    assign rd_perm = ram_rdata[6:0];
    assign act     = vec_reg[rd_addr[9:6]][rd_addr[5:0]];
    assign masked  = cmd_reg.learn_mask[r_reg];
    assign last    = ({1'b0, r_reg} == (cfg.receptors - 6'd1));
    assign bits    = avail_reg[nxt_reg[9:6]] & ({64{1'b1}} << nxt_reg[5:0]);
    assign pos     = lowest_set(bits);

    // Sequencer over the receptors of one dendrite.
    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        r_next         = r_reg;
        ov_next        = ov_reg;
        nxt_next       = nxt_reg;
        clr_next       = clr_reg;
        vec_next       = vec_reg;
        avail_next     = avail_reg;
        res_valid_next = res_valid_reg && result_stall;
        res_next       = res_reg;
        ram_we         = 1'b0;
        ram_waddr      = slot;
        ram_wdata      = ram_rdata;
        ram_raddr      = slot;

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == {SLOT_AW{1'b1}})
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (q_pop)
                begin
                    cmd_next = q_cmd;
                    r_next   = 5'd0;
                    ov_next  = 6'd0;
                    res_next = '0;
                    case (q_cmd.op)
                        OP_LOAD:
                        begin
                            vec_next[q_cmd.word_index] = q_cmd.word_data;
                            res_valid_next = 1'b1;
                        end
                        OP_WRITE:
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = {q_cmd.dendrite, q_cmd.receptor};
                            ram_wdata = {q_cmd.address, q_cmd.permanence};
                            res_valid_next = 1'b1;
                        end
                        OP_READ:
                        begin
                            ram_raddr  = {q_cmd.dendrite, q_cmd.receptor};
                            state_next = ST_READ;
                        end
                        OP_OVERLAP, OP_LEARN, OP_PUNISH:
                        begin
                            if (cfg.receptors == 6'd0)
                            begin
                                res_valid_next = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_WALK_RD;
                            end
                        end
                        OP_MOVE:
                        begin
                            if (cfg.receptors == 6'd0)
                            begin
                                res_valid_next = 1'b1;
                            end
                            else
                            begin
                                avail_next = vec_reg;
                                state_next = ST_FREE_RD;
                            end
                        end
                        default:
                        begin
                            res_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                res_next.overlap_count   = 6'd0;
                res_next.read_address    = rd_addr;
                res_next.read_permanence = rd_perm;
                res_valid_next           = 1'b1;
                state_next               = ST_IDLE;
            end
            ST_WALK_RD:
            begin
                state_next = ST_WALK_EX;
            end
            ST_WALK_EX:
            begin
                // Count, learn or punish one receptor.
                if (cmd_reg.op == OP_OVERLAP)
                begin
                    if ((rd_perm >= cfg.threshold) && act)
                    begin
                        ov_next = ov_reg + 6'd1;
                    end
                end
                else if (cmd_reg.op == OP_LEARN)
                begin
                    ram_we    = masked;
                    ram_wdata = {rd_addr, act ? perm_up(rd_perm, cfg.increment)
                                              : perm_down(rd_perm, cfg.decrement)};
                end
                else
                begin
                    ram_we    = masked && act;
                    ram_wdata = {rd_addr, perm_down(rd_perm, cfg.increment)};
                end
                if (last)
                begin
                    res_next = '0;
                    if (cmd_reg.op == OP_OVERLAP)
                    begin
                        res_next.overlap_count = ov_next;
                    end
                    res_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    r_next     = r_reg + 5'd1;
                    state_next = ST_WALK_RD;
                end
            end
            ST_FREE_RD:
            begin
                state_next = ST_FREE_EX;
            end
            ST_FREE_EX:
            begin
                // Addresses already held by live receptors are not free.
                if (rd_perm != 7'd0)
                begin
                    avail_next[rd_addr[9:6]][rd_addr[5:0]] = 1'b0;
                end
                if (last)
                begin
                    r_next     = 5'd0;
                    nxt_next   = 11'd0;
                    state_next = ST_MOVE_RD;
                end
                else
                begin
                    r_next     = r_reg + 5'd1;
                    state_next = ST_FREE_RD;
                end
            end
            ST_MOVE_RD:
            begin
                state_next = ST_MOVE_EX;
            end
            ST_MOVE_EX:
            begin
                if (masked && (rd_perm == 7'd0))
                begin
                    state_next = ST_SEARCH;
                end
                else
                begin
                    ram_we    = masked;
                    ram_wdata = {rd_addr, act ? perm_up(rd_perm, cfg.increment)
                                              : perm_down(rd_perm, cfg.decrement)};
                    if (last)
                    begin
                        res_next       = '0;
                        res_valid_next = 1'b1;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        r_next     = r_reg + 5'd1;
                        state_next = ST_MOVE_RD;
                    end
                end
            end
            ST_SEARCH:
            begin
                // Scan one word of the free set per cycle.
                if (!nxt_reg[10] && (bits == 64'd0))
                begin
                    nxt_next = {1'b0, nxt_reg[9:6], 6'd0} + 11'd64;
                end
                else
                begin
                    if (!nxt_reg[10])
                    begin
                        ram_we    = 1'b1;
                        ram_wdata = {nxt_reg[9:6], pos, cfg.threshold};
                        avail_next[nxt_reg[9:6]][pos] = 1'b0;
                        nxt_next  = {1'b0, nxt_reg[9:6], pos};
                    end
                    if (last)
                    begin
                        res_next       = '0;
                        res_valid_next = 1'b1;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        r_next     = r_reg + 5'd1;
                        state_next = ST_MOVE_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state and the input vector.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            res_valid_reg <= 1'b0;
            vec_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            res_valid_reg <= res_valid_next;
            vec_reg       <= vec_next;
        end
    end

    // Working payload registers.
    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        r_reg     <= r_next;
        ov_reg    <= ov_next;
        nxt_reg   <= nxt_next;
        avail_reg <= avail_next;
        res_reg   <= res_next;
    end

endmodule

FILE: src/dendrite_overlap_and_learning.sv
// Dendrite store with overlap and learning.
// Input channel (item_valid, item_stall, item) takes one item per handshake:
// load a vector word, write or read a receptor, overlap, learn, punish or
// learn-move on a dendrite. Each item gives exactly one result item on the
// output channel (result_valid, result_stall, result), in order.
// A two-entry queue sits between the classifying front and the sequencer,
// so new items are taken while a result waits for the receiver.
// The sequencer handles one item at a time. Load, write and ignored items
// need no memory walk; a read waits on the registered read port of the slot
// memory; overlap, learn and punish read and then process each of the R
// receptors in use; learn-move walks them twice, first to find the free set
// and then to update them, with a search for each masked empty receptor that
// steps over empty words of the free set. The next item starts the cycle
// after a result is taken.
// After reset the slot memory is swept to zero, one entry a cycle over all 8192
// entries, and no item is taken until it is done; configuration writes go on.
// While the receiver stalls, the result holds and the queue fills, after
// which item_stall rises.
// Configuration sits on an APB-style port, register i at byte address 4*i.
module dendrite_overlap_and_learning (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          item_valid,
    output logic          item_stall,
    input  dol_pkg::in_t  item,
    output logic          result_valid,
    input  logic          result_stall,
    output dol_pkg::out_t result,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    import dol_pkg::*;

    logic [6:0] thr_reg;
    logic [6:0] inc_reg;
    logic [6:0] dec_reg;
    logic [5:0] ru_reg;
    logic [8:0] du_reg;
    logic [6:0] perm_wr;
    logic       wr_en;
    cfg_t       cfg;
    logic [8:0] dendrites;
    logic       clearing;
    logic       q_pop;
    logic       q_valid;
    cmd_t       q_cmd;

    // Register writes; permanence values are clamped to the top value.
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign perm_wr = (pwdata[6:0] > PERM_TOP) ? PERM_TOP : pwdata[6:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= 7'd20;
            inc_reg <= 7'd2;
            dec_reg <= 7'd1;
            ru_reg  <= 6'd32;
            du_reg  <= 9'd256;
        end
        else if (wr_en)
        begin
            case (paddr[4:2])
                REG_THRESHOLD: thr_reg <= perm_wr;
                REG_INCREMENT: inc_reg <= perm_wr;
                REG_DECREMENT: dec_reg <= perm_wr;
                REG_RECEPTORS: ru_reg  <= pwdata[5:0];
                REG_DENDRITES: du_reg  <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    // Register reads.
    always_comb
    begin
        case (paddr[4:2])
            REG_THRESHOLD: prdata = {25'd0, thr_reg};
            REG_INCREMENT: prdata = {25'd0, inc_reg};
            REG_DECREMENT: prdata = {25'd0, dec_reg};
            REG_RECEPTORS: prdata = {26'd0, ru_reg};
            REG_DENDRITES: prdata = {23'd0, du_reg};
            default:       prdata = 32'd0;
        endcase
    end

    // Effective limits.
    always_comb
    begin
        cfg.threshold = thr_reg;
        cfg.increment = inc_reg;
        cfg.decrement = dec_reg;
        cfg.receptors = (ru_reg > 6'(MAX_RECEPTORS)) ? 6'(MAX_RECEPTORS) : ru_reg;
        dendrites     = (du_reg > 9'(MAX_DENDRITES)) ? 9'(MAX_DENDRITES) : du_reg;
    end

    dol_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .item      (item),
        .receptors (cfg.receptors),
        .dendrites (dendrites),
        .clearing  (clearing),
        .q_pop     (q_pop),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd)
    );

    dol_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .q_valid     (q_valid),
        .q_cmd       (q_cmd),
        .q_pop       (q_pop),
        .clearing    (clearing),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result      (result)
    );

    // The back only takes from a queue that holds an item.
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    // Nothing enters or leaves the queue during the memory sweep.
    a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> (!q_pop && !(item_valid && !item_stall)))
        else $error("item moved during memory sweep");

    // A new item starts only when no result is waiting.
    a_pop_free: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !result_valid)
        else $error("item started while a result waits");

endmodule

FILE: tb/tb_dendrite_overlap_and_learning.sv
`timescale 1ns / 100ps

module tb_dendrite_overlap_and_learning;
    import dol_pkg::*;

    localparam int STALL_LIMIT = 30000;

    // Model of the dendrite store and queue of the results it predicts.
    class dendrite_scoreboard;
        logic [63:0] vec [VEC_WORDS];
        logic [9:0]  addr_mem [SLOTS];
        logic [6:0]  perm_mem [SLOTS];
        int unsigned thr;
        int unsigned inc;
        int unsigned dec;
        int unsigned rx_reg;
        int unsigned dn_reg;
        out_t        pending_results [$];
        int          errors;

        function new();
            thr = 20;
            inc = 2;
            dec = 1;
            rx_reg = 32;
            dn_reg = 256;
            errors = 0;
            foreach (vec[i]) vec[i] = '0;
            foreach (addr_mem[i]) addr_mem[i] = '0;
            foreach (perm_mem[i]) perm_mem[i] = '0;
        endfunction

        function int unsigned clip_perm(int unsigned v);
            return (v > PERM_TOP) ? PERM_TOP : v;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] value);
            case (idx)
                REG_THRESHOLD: thr = clip_perm(value[6:0]);
                REG_INCREMENT: inc = clip_perm(value[6:0]);
                REG_DECREMENT: dec = clip_perm(value[6:0]);
                REG_RECEPTORS: rx_reg = value[5:0];
                REG_DENDRITES: dn_reg = value[8:0];
                default: ;
            endcase
        endfunction

        function int unsigned rx_eff();
            return (rx_reg < MAX_RECEPTORS) ? rx_reg : MAX_RECEPTORS;
        endfunction

        function int unsigned dn_eff();
            return (dn_reg < MAX_DENDRITES) ? dn_reg : MAX_DENDRITES;
        endfunction

        function bit bit_at(logic [63:0] v [VEC_WORDS], int unsigned a);
            if (a >= INPUT_BITS)
                return 1'b0;
            return v[a / 64][a % 64];
        endfunction

        function int unsigned raise(int unsigned p);
            return clip_perm(p + inc);
        endfunction

        function int unsigned lower(int unsigned p, int unsigned amount);
            return (p > amount) ? p - amount : 0;
        endfunction

        function int size();
            return pending_results.size();
        endfunction

        // Apply one accepted item to the model and queue its result.
        function void note_item(in_t it);
            out_t        res;
            int unsigned rn;
            int unsigned base;
            int unsigned s;
            int unsigned nxt;
            bit          act;
            logic [63:0] avail [VEC_WORDS];
            res = '0;
            rn = rx_eff();
            base = it.dendrite * MAX_RECEPTORS;
            if (it.kind == KIND_LOAD)
            begin
                vec[it.word_index] = it.word_data;
            end
            else if (it.kind <= KIND_READ && it.dendrite < dn_eff())
            begin
                case (it.kind)
                    KIND_WRITE:
                    begin
                        if (it.receptor < rn)
                        begin
                            addr_mem[base + it.receptor] = it.receptor_address;
                            perm_mem[base + it.receptor] = clip_perm(it.receptor_permanence);
                        end
                    end
                    KIND_READ:
                    begin
                        if (it.receptor < rn)
                        begin
                            res.read_address = addr_mem[base + it.receptor];
                            res.read_permanence = perm_mem[base + it.receptor];
                        end
                    end
                    KIND_OVERLAP:
                    begin
                        for (int r = 0; r < rn; r++)
                            if (perm_mem[base + r] >= thr && bit_at(vec, addr_mem[base + r]))
                                res.overlap_count++;
                    end
                    KIND_LEARN, KIND_PUNISH:
                    begin
                        for (int r = 0; r < rn; r++)
                        begin
                            s = base + r;
                            if (it.learn_mask[r])
                            begin
                                act = bit_at(vec, addr_mem[s]);
                                if (it.kind == KIND_LEARN)
                                    perm_mem[s] = act ? raise(perm_mem[s]) : lower(perm_mem[s], dec);
                                else if (act)
                                    perm_mem[s] = lower(perm_mem[s], inc);
                            end
                        end
                    end
                    default:
                    begin
                        // Learn-move: free bits are active bits not used by live slots.
                        avail = vec;
                        nxt = 0;
                        for (int r = 0; r < rn; r++)
                            if (perm_mem[base + r] > 0)
                                avail[addr_mem[base + r] / 64][addr_mem[base + r] % 64] = 1'b0;
                        for (int r = 0; r < rn; r++)
                        begin
                            s = base + r;
                            if (it.learn_mask[r])
                            begin
                                if (perm_mem[s] > 0)
                                begin
                                    perm_mem[s] = bit_at(vec, addr_mem[s]) ? raise(perm_mem[s])
                                                                          : lower(perm_mem[s], dec);
                                end
                                else
                                begin
                                    while (nxt < INPUT_BITS && !bit_at(avail, nxt))
                                        nxt++;
                                    if (nxt < INPUT_BITS)
                                    begin
                                        addr_mem[s] = nxt;
                                        perm_mem[s] = thr;
                                        avail[nxt / 64][nxt % 64] = 1'b0;
                                    end
                                end
                            end
                        end
                    end
                endcase
            end
            pending_results.push_back(res);
        endfunction

        // Compare one accepted result with the oldest prediction.
        function void check_result(out_t got);
            out_t exp_res;
            if (pending_results.size() == 0)
            begin
                $error("result item with nothing expected: %h", got);
                errors++;
                return;
            end
            exp_res = pending_results.pop_front();
            if (got.overlap_count !== exp_res.overlap_count)
            begin
                $error("overlap_count expected %0d actual %0d",
                       exp_res.overlap_count, got.overlap_count);
                errors++;
            end
            if (got.read_address !== exp_res.read_address)
            begin
                $error("read_address expected %0d actual %0d",
                       exp_res.read_address, got.read_address);
                errors++;
            end
            if (got.read_permanence !== exp_res.read_permanence)
            begin
                $error("read_permanence expected %0d actual %0d",
                       exp_res.read_permanence, got.read_permanence);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_stall;
    in_t         item;
    logic        result_valid;
    logic        result_stall;
    out_t        result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    dendrite_scoreboard sb;
    int  idle_mode;
    bit  moved;
    int  quiet_cycles;

    dendrite_overlap_and_learning u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // Free-running clock.
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Receiver stalls at random in the phases that call for it.
    always @(negedge clk)
    begin
        if (idle_mode == 2)
            result_stall = ($urandom_range(99) < 80);
        else if (idle_mode == 3)
            result_stall = ($urandom_range(99) < 22);
        else
            result_stall = 1'b0;
    end

    // Result monitor and watchdog.
    always @(posedge clk)
    begin
        moved = 1'b0;
        if (rst_n && result_valid && !result_stall)
        begin
            sb.check_result(result);
            moved = 1'b1;
        end
        if (rst_n && item_valid && !item_stall)
            moved = 1'b1;
        quiet_cycles = moved ? 0 : quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Number of idle cycles before the next item.
    function automatic int sender_gap();
        int g;
        int pct;
        g = 0;
        pct = (idle_mode == 1) ? 80 : (idle_mode == 3) ? 22 : 0;
        while ($urandom_range(99) < pct && g < 200)
            g++;
        return g;
    endfunction

    // Present one item and hold it until the block takes it.
    task automatic push_item(in_t it);
        int g;
        g = sender_gap();
        @(negedge clk);
        if (g > 0)
        begin
            item_valid = 1'b0;
            repeat (g) @(negedge clk);
        end
        item_valid = 1'b1;
        item = it;
        forever
        begin
            @(posedge clk);
            if (!item_stall)
                break;
        end
        sb.note_item(it);
    endtask

    // One register write over the configuration port.
    task automatic reg_write(logic [2:0] idx, logic [31:0] value);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        forever
        begin
            @(posedge clk);
            if (pready)
                break;
        end
        sb.set_reg(idx, value);
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    // Let the block drain before anything else happens.
    task automatic wait_drained();
        @(negedge clk);
        item_valid = 1'b0;
        while (sb.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // New register setting, written only once the block is idle.
    task automatic set_config(int th, int inc, int dec, int rx, int dn);
        wait_drained();
        reg_write(REG_THRESHOLD, th);
        reg_write(REG_INCREMENT, inc);
        reg_write(REG_DECREMENT, dec);
        reg_write(REG_RECEPTORS, rx);
        reg_write(REG_DENDRITES, dn);
    endtask

    function automatic in_t make_item(logic [2:0] k, int d, int r, int a, int p,
                                      logic [31:0] m);
        in_t it;
        it = '0;
        it.kind = k;
        it.dendrite = d;
        it.receptor = r;
        it.receptor_address = a;
        it.receptor_permanence = p;
        it.learn_mask = m;
        return it;
    endfunction

    function automatic in_t make_load(int w, logic [63:0] data);
        in_t it;
        it = '0;
        it.kind = KIND_LOAD;
        it.word_index = w;
        it.word_data = data;
        return it;
    endfunction

    // Random item, mostly aimed at a few dendrites and slots in use.
    function automatic in_t random_item();
        in_t it;
        int  pick;
        int  dn;
        int  rn;
        dn = sb.dn_eff();
        rn = sb.rx_eff();
        it.word_index = $urandom;
        it.word_data = {$urandom, $urandom};
        if ($urandom_range(3) == 0)
            it.word_data = it.word_data & {$urandom, $urandom};
        it.dendrite = $urandom;
        if (dn > 0 && $urandom_range(9) != 0)
            it.dendrite = $urandom_range(((dn < 6) ? dn : 6) - 1);
        it.receptor = $urandom;
        if (rn > 0 && $urandom_range(9) != 0)
            it.receptor = $urandom_range(rn - 1);
        it.receptor_address = $urandom;
        pick = $urandom_range(9);
        it.receptor_permanence = (pick < 3) ? 7'd0 :
                                 (pick < 8) ? 7'($urandom_range(0, 99)) : 7'($urandom);
        it.learn_mask = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF : $urandom;
        pick = $urandom_range(99);
        if (pick < 14)
            it.kind = KIND_LOAD;
        else if (pick < 38)
            it.kind = KIND_WRITE;
        else if (pick < 53)
            it.kind = KIND_OVERLAP;
        else if (pick < 67)
            it.kind = KIND_LEARN;
        else if (pick < 76)
            it.kind = KIND_PUNISH;
        else if (pick < 87)
            it.kind = KIND_MOVE;
        else if (pick < 98)
            it.kind = KIND_READ;
        else
            it.kind = 3'd7;
        return it;
    endfunction

    task automatic random_phase(int count, int mode);
        idle_mode = mode;
        for (int i = 0; i < count; i++)
        begin
            push_item(random_item());
            // Sender holds off once until every result has arrived.
            if (mode == 3 && i == count / 2)
                wait_drained();
        end
        idle_mode = 0;
    endtask

    // Main sequence.
    initial
    begin
        sb = new();
        idle_mode = 0;
        quiet_cycles = 0;
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        result_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed items under the reset configuration.
        push_item(make_load(0, 64'hFFFF_FFFF_FFFF_FFFF));
        push_item(make_load(15, 64'h8000_0000_0000_0001));
        push_item(make_load(1, 64'h0));
        push_item(make_item(KIND_WRITE, 0, 0, 0, 127, '0));
        push_item(make_item(KIND_WRITE, 0, 31, 1023, 99, '0));
        push_item(make_item(KIND_WRITE, 0, 1, 64, 50, '0));
        push_item(make_item(KIND_WRITE, 255, 5, 3, 0, '0));
        push_item(make_item(KIND_READ, 0, 0, 0, 0, '0));
        push_item(make_item(KIND_OVERLAP, 0, 0, 0, 0, '0));
        push_item(make_item(KIND_LEARN, 0, 0, 0, 0, 32'hFFFF_FFFF));
        push_item(make_item(KIND_PUNISH, 0, 0, 0, 0, 32'h8000_0001));
        push_item(make_item(KIND_MOVE, 0, 0, 0, 0, 32'hFFFF_FFFF));
        push_item(make_item(KIND_MOVE, 255, 0, 0, 0, 32'h0000_00F0));
        push_item(make_item(KIND_READ, 0, 31, 0, 0, '0));
        push_item(make_item(KIND_READ, 0, 2, 0, 0, '0));
        push_item(make_item(KIND_READ, 255, 5, 0, 0, '0));
        push_item(make_item(3'd7, 0, 0, 0, 0, 32'hFFFF_FFFF));
        push_item(make_item(KIND_OVERLAP, 255, 0, 0, 0, '0));

        set_config(20, 2, 1, 32, 8);
        random_phase(300, 0);
        set_config(0, 99, 99, 1, 1);
        random_phase(150, 1);
        set_config(99, 0, 0, 8, 4);
        random_phase(280, 2);
        set_config(127, 127, 127, 63, 511);
        random_phase(200, 3);
        set_config(30, 5, 3, 0, 5);
        random_phase(50, 0);
        set_config(10, 3, 2, 16, 0);
        random_phase(50, 1);
        set_config(25, 4, 2, 12, 6);
        random_phase(400, 3);
        set_config(15, 7, 5, 32, 3);
        random_phase(400, 2);

        // Drain and finish.
        wait_drained();
        repeat (800) @(posedge clk);
        if (sb.errors == 0 && sb.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
